// File: design/acthq_pkg.sv
package acthq_pkg;

    // Field widths
    localparam int CH_W   = 3;
    localparam int SMP_W  = 10;
    localparam int CV_W   = 7;
    localparam int LVL_W  = 11;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 10;

    // Channel count defaults and the channel space that the input field can address
    localparam int CHANNELS_DEF = 8;
    localparam int CH_SPACE     = 2 ** CH_W;
    localparam int MASK_W       = 8;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_MASK    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PRESS   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RELEASE = 2'd2;

    // Register reset values
    localparam logic [MASK_W-1:0] MASK_RST    = 8'd0;
    localparam logic [SMP_W-1:0]  PRESS_RST   = 10'd150;
    localparam logic [SMP_W-1:0]  RELEASE_RST = 10'd50;

    // Control value limits and sample clamp points
    localparam logic [CV_W-1:0]  CV_MAX = 7'd127;
    localparam logic [CV_W-1:0]  CV_MIN = 7'd0;
    localparam logic [SMP_W-1:0] SMP_LO = 10'd3;
    localparam logic [SMP_W-1:0] SMP_HI = 10'd1020;

    // Sample to value: floor(t * 1000 / 8095) as (t * RECIP) >> SHIFT, exact for t <= 1017
    localparam int VAL_SHIFT = 24;
    localparam int RECIP_W   = 21;
    localparam int PROD_W    = SMP_W + RECIP_W;
    localparam logic [RECIP_W-1:0] VAL_RECIP =
        RECIP_W'(((64'd1 << VAL_SHIFT) * 64'd1000 + 64'd8094) / 64'd8095);

    // Level table, entries 0..128
    localparam int LVL_N = 129;
    typedef logic [LVL_W-1:0] t_level;
    typedef t_level [LVL_N-1:0] t_level_tab;

    function automatic t_level_tab f_level_tab();
        t_level_tab tab;
        int         lvl;
        for (int c = 0; c < LVL_N; c++) begin
            if (c == 0) begin
                lvl = 0;
            end else if (c == 127) begin
                lvl = 1020;
            end else begin
                lvl = 3 + ((c - 1) * 8095) / 1000;
            end
            tab[c] = LVL_W'(lvl);
        end
        return tab;
    endfunction

    localparam t_level_tab LEVEL_TAB = f_level_tab();

    // Payload types
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic [CV_W-1:0] control_value;
    } t_out_item;

    // Item held in the evaluate stage
    typedef struct packed {
        logic             hit;
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic [CV_W-1:0]  value;
    } t_s1_item;

    // Write-back request to the state memory
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] chan;
        logic [CV_W-1:0] data;
    } t_mem_wr;

    // Evaluate result
    typedef struct packed {
        logic            emit;
        logic [CV_W-1:0] next;
    } t_eval_res;

endpackage

// File: design/acthq_mem.sv
module acthq_mem #(
    parameter int DEPTH = acthq_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [acthq_pkg::CH_W-1:0]  i_rd_chan,
    input  acthq_pkg::t_mem_wr          i_wr,
    output logic [acthq_pkg::CV_W-1:0]  o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [acthq_pkg::CV_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [acthq_pkg::CV_W-1:0] r_rd_q;
    logic                       r_rd_ok;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_fwd_vld;
    logic [AW-1:0]              r_fwd_addr;
    logic [acthq_pkg::CV_W-1:0] r_fwd_data;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign rd_addr = i_rd_chan[AW-1:0];
    assign wr_addr = i_wr.chan[AW-1:0];

    // Storage array and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_q    <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // Written-entry flags; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_vld[rd_addr];
            end
        end
    end

    // Last write, for a read taken at the same edge as that write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= wr_addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_q;
        end else begin
            o_rd_data = acthq_pkg::CV_MIN;
        end
    end

endmodule

// File: design/acthq_eval.sv
module acthq_eval (
    input  acthq_pkg::t_s1_item           i_item,
    input  logic [acthq_pkg::CV_W-1:0]    i_last,
    input  logic [acthq_pkg::MASK_W-1:0]  i_mask,
    input  logic [acthq_pkg::SMP_W-1:0]   i_press,
    input  logic [acthq_pkg::SMP_W-1:0]   i_release,
    output acthq_pkg::t_eval_res          o_res
);

    localparam int CW = acthq_pkg::LVL_W + 1;

    logic                       button;
    logic [acthq_pkg::CV_W-1:0] btn_next;
    logic [acthq_pkg::LVL_W-1:0] lvl_lo;
    logic [acthq_pkg::LVL_W-1:0] lvl_hi;
    logic [CW-1:0]              smp_x;
    logic                       inside_win;
    logic [7:0]                 last_up;

    assign button  = i_mask[i_item.channel];
    assign last_up = {1'b0, i_last} + 8'd1;

    // Button hysteresis: press rule from zero, release rule from anything else
    always_comb begin
        if (i_last == acthq_pkg::CV_MIN) begin
            btn_next = (i_item.sample > i_press) ? acthq_pkg::CV_MAX : acthq_pkg::CV_MIN;
        end else begin
            btn_next = (i_item.sample < i_release) ? acthq_pkg::CV_MIN : acthq_pkg::CV_MAX;
        end
    end

    // Knob window: level(last) - 2 <= s <= level(last + 1) + 1
    assign lvl_lo     = acthq_pkg::LEVEL_TAB[i_last];
    assign lvl_hi     = acthq_pkg::LEVEL_TAB[last_up];
    assign smp_x      = CW'(i_item.sample);
    assign inside_win = ((smp_x + CW'(2)) >= CW'(lvl_lo)) &&
                        (smp_x <= (CW'(lvl_hi) + CW'(1)));

    always_comb begin
        o_res.emit = 1'b0;
        o_res.next = i_item.value;
        if (i_item.hit) begin
            if (button) begin
                o_res.next = btn_next;
                o_res.emit = (btn_next != i_last);
            end else begin
                o_res.emit = !inside_win;
            end
        end
    end

endmodule

// File: design/adc_to_cc_hysteresis_qualifier_top.sv
// Channel  Direction  Handshake          Payload
// in       input      i_in_valid/o_in_stall    t_in_item {channel, sample}
// out      output     o_out_valid/i_out_stall  t_out_item {out_channel, control_value}
// cfg      input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle unless the output backs up; results pass the stage 1 and output registers.
// Stage 0 reads the per-channel state memory and scales the sample; stage 1 evaluates
// and writes back, with the previous write forwarded for a same-channel follower.
// Reset clears the written-entry flags, so all control state reads as zero; no sweep.
// An output stall holds a result in the output register and backs up into stage 1 only
// when that stage also has a result to hand over.
module adc_to_cc_hysteresis_qualifier_top #(
    parameter int CHANNELS = acthq_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  acthq_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output acthq_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [acthq_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [acthq_pkg::CFG_DW-1:0]  i_cfg_data
);

    localparam int DEPTH = (CHANNELS < acthq_pkg::CH_SPACE) ? CHANNELS : acthq_pkg::CH_SPACE;

    logic [acthq_pkg::MASK_W-1:0] r_mask;
    logic [acthq_pkg::SMP_W-1:0]  r_press;
    logic [acthq_pkg::SMP_W-1:0]  r_release;

    logic                 r_s1_vld;
    acthq_pkg::t_s1_item  r_s1;
    acthq_pkg::t_s1_item  n_s1;
    logic                 r_out_vld;
    acthq_pkg::t_out_item r_out;

    logic                            in_acc;
    logic                            s1_adv;
    logic [acthq_pkg::SMP_W-1:0]     s0_off;
    logic [acthq_pkg::PROD_W-1:0]    s0_prod;
    logic [acthq_pkg::CV_W-1:0]      last;
    acthq_pkg::t_eval_res            res;
    acthq_pkg::t_mem_wr              wr;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= acthq_pkg::MASK_RST;
            r_press   <= acthq_pkg::PRESS_RST;
            r_release <= acthq_pkg::RELEASE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acthq_pkg::CFG_MASK:    r_mask    <= i_cfg_data[acthq_pkg::MASK_W-1:0];
                acthq_pkg::CFG_PRESS:   r_press   <= i_cfg_data[acthq_pkg::SMP_W-1:0];
                acthq_pkg::CFG_RELEASE: r_release <= i_cfg_data[acthq_pkg::SMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves on unless it has a result and the output is blocked
    assign s1_adv     = r_s1_vld && (!res.emit || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Stage 0: range check and sample scaling
    assign s0_off  = i_in_data.sample - acthq_pkg::SMP_LO;
    assign s0_prod = acthq_pkg::PROD_W'(s0_off) * acthq_pkg::PROD_W'(acthq_pkg::VAL_RECIP);

    always_comb begin
        n_s1.hit     = (int'(i_in_data.channel) < CHANNELS);
        n_s1.channel = i_in_data.channel;
        n_s1.sample  = i_in_data.sample;
        if (i_in_data.sample < acthq_pkg::SMP_LO) begin
            n_s1.value = acthq_pkg::CV_MIN;
        end else if (i_in_data.sample > acthq_pkg::SMP_HI) begin
            n_s1.value = acthq_pkg::CV_MAX;
        end else begin
            n_s1.value = s0_prod[acthq_pkg::PROD_W-1 -: acthq_pkg::CV_W] + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // State memory
    acthq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && n_s1.hit),
        .i_rd_chan (i_in_data.channel),
        .i_wr      (wr),
        .o_rd_data (last)
    );

    // Stage 1: evaluate and write back
    acthq_eval u_eval (
        .i_item    (r_s1),
        .i_last    (last),
        .i_mask    (r_mask),
        .i_press   (r_press),
        .i_release (r_release),
        .o_res     (res)
    );

    assign wr.en   = s1_adv && res.emit;
    assign wr.chan = r_s1.channel;
    assign wr.data = res.next;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (wr.en) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            r_out.out_channel   <= r_s1.channel;
            r_out.control_value <= res.next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: tb/tb_adc_to_cc_hysteresis_qualifier_top.sv
module tb_adc_to_cc_hysteresis_qualifier_top;

    localparam int NCH          = acthq_pkg::CHANNELS_DEF;
    localparam int STUCK_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 250;
    // index with no register behind it; writes must be ignored
    localparam logic [acthq_pkg::CFG_IW-1:0] CFG_SPARE = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    acthq_pkg::t_in_item            i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    acthq_pkg::t_out_item           o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [acthq_pkg::CFG_IW-1:0]   i_cfg_index = '0;
    logic [acthq_pkg::CFG_DW-1:0]   i_cfg_data = '0;

    adc_to_cc_hysteresis_qualifier_top #(.CHANNELS(NCH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the block's registers and per-channel control state
    logic [acthq_pkg::MASK_W-1:0] mode_mask = acthq_pkg::MASK_RST;
    logic [acthq_pkg::SMP_W-1:0]  press_lvl = acthq_pkg::PRESS_RST;
    logic [acthq_pkg::SMP_W-1:0]  release_lvl = acthq_pkg::RELEASE_RST;
    logic [acthq_pkg::CV_W-1:0]   cv_state [NCH];

    acthq_pkg::t_out_item cv_expected [$];
    int        err_cnt = 0;
    int        stuck = 0;
    bit        no_idle = 1'b0;
    bit        out_took = 1'b0;
    int        hold_left = 0;
    int        prev_ch = 0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;
    wire cfg_fire = i_cfg_valid && o_cfg_ready;

    initial begin
        for (int c = 0; c < NCH; c++) cv_state[c] = '0;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Value-to-level and sample-to-value scaling, 8.095 counts per step
    function automatic int cv_level(int c);
        if (c == 0) return 0;
        if (c == 127) return 1020;
        return 3 + ((c - 1) * 8095) / 1000;
    endfunction

    function automatic int sample_value(int s);
        if (s < 3) return 0;
        if (s > 1020) return 127;
        return 1 + ((s - 3) * 1000) / 8095;
    endfunction

    // Predict the result of one request and update the shadow state
    function automatic bit qualify(input acthq_pkg::t_in_item it,
                                   output acthq_pkg::t_out_item res);
        int ch;
        int s;
        int last;
        int nxt;
        ch   = int'(it.channel);
        s    = int'(it.sample);
        res  = '0;
        if (ch >= NCH) return 1'b0;
        last = int'(cv_state[ch]);
        if (ch < acthq_pkg::MASK_W && mode_mask[ch]) begin
            // button: press rule only from a stored zero
            if (last == 0) nxt = (s > int'(press_lvl)) ? 127 : 0;
            else nxt = (s < int'(release_lvl)) ? 0 : 127;
            if (nxt == last) return 1'b0;
        end else begin
            // knob: hold inside the window around the stored level
            if (s >= cv_level(last) - 2 && s <= cv_level(last + 1) + 1) return 1'b0;
            nxt = sample_value(s);
        end
        cv_state[ch]      = acthq_pkg::CV_W'(nxt);
        res.out_channel   = acthq_pkg::CH_W'(ch);
        res.control_value = acthq_pkg::CV_W'(nxt);
        return 1'b1;
    endfunction

    task automatic log_mismatch(string what, acthq_pkg::t_out_item want,
                                acthq_pkg::t_out_item got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s: expected ch %0d cv %0d, got ch %0d cv %0d", $realtime, what,
                     want.out_channel, want.control_value, got.out_channel,
                     got.control_value);
    endtask

    // Result checking, register shadowing and prediction, all on the rising edge
    always @(posedge i_clk) begin
        acthq_pkg::t_out_item want;
        acthq_pkg::t_out_item got;
        if (!i_rst_n) begin
            out_took = 1'b0;
        end else begin
            out_took = out_fire;
            if (out_fire) begin
                got = o_out_data;
                if (cv_expected.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end else begin
                    want = cv_expected.pop_front();
                    if (got.out_channel != want.out_channel ||
                        got.control_value != want.control_value)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    acthq_pkg::CFG_MASK:
                        mode_mask   = i_cfg_data[acthq_pkg::MASK_W-1:0];
                    acthq_pkg::CFG_PRESS:
                        press_lvl   = i_cfg_data[acthq_pkg::SMP_W-1:0];
                    acthq_pkg::CFG_RELEASE:
                        release_lvl = i_cfg_data[acthq_pkg::SMP_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                if (qualify(i_in_data, want)) cv_expected.push_back(want);
            end
        end
    end

    // Output stall: a fresh hold is drawn after every taken result
    always @(negedge i_clk) begin
        if (out_took) hold_left = idle_draw();
        i_out_stall = (hold_left > 0);
        if (hold_left > 0) hold_left--;
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (in_fire || out_fire || cfg_fire) stuck = 0;
        else stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("adc_to_cc_hysteresis_qualifier_top verification failed");
            $finish;
        end
    end

    // Send one request; entered and left at a falling edge, valid stays up after
    task automatic send_sample(int ch, int s);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_in_data.channel = acthq_pkg::CH_W'(ch);
        i_in_data.sample  = acthq_pkg::SMP_W'(s);
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        prev_ch = ch;
    endtask

    // Let every pending result out, then let silent requests clear
    task automatic drain();
        i_in_valid = 1'b0;
        while (cv_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [acthq_pkg::CFG_IW-1:0] idx, int data);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = acthq_pkg::CFG_DW'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic int clamp_sample(int s);
        if (s < 0) return 0;
        if (s > 1023) return 1023;
        return s;
    endfunction

    // Samples aimed at window edges, thresholds and range ends
    function automatic int pick_sample(int ch);
        int k;
        int last;
        k    = $urandom_range(0, 9);
        last = int'(cv_state[ch]);
        case (k)
            3, 4: return clamp_sample(cv_level(last) - 2 + $urandom_range(0, 4) - 2);
            5:    return clamp_sample(cv_level(last + 1) + 1 + $urandom_range(0, 4) - 2);
            6:    return clamp_sample(int'(press_lvl) + $urandom_range(0, 4) - 2);
            7:    return clamp_sample(int'(release_lvl) + $urandom_range(0, 4) - 2);
            8:    return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(1020, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1023;
            2: return $urandom_range(20, 200);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Knob mapping from reset: window holds, steps, both range ends
    task automatic test_knob_map();
        send_sample(0, 0);
        send_sample(0, 4);
        send_sample(0, 5);
        send_sample(0, 0);
        send_sample(7, 1023);
        send_sample(7, 1020);
        send_sample(7, 1017);
        send_sample(3, 2);
        send_sample(3, 600);
        send_sample(5, 3);
        send_sample(6, 1021);
    endtask

    // Button hysteresis at the default thresholds, incl. non-binary stored values
    task automatic test_button_hysteresis();
        write_reg(acthq_pkg::CFG_MASK, 'h89);
        send_sample(0, 150);
        send_sample(0, 151);
        send_sample(0, 50);
        send_sample(0, 49);
        send_sample(3, 600);
        send_sample(7, 0);
    endtask

    // Thresholds at their extremes, in both orders
    task automatic test_threshold_extremes();
        write_reg(acthq_pkg::CFG_PRESS, 0);
        write_reg(acthq_pkg::CFG_RELEASE, 1023);
        send_sample(0, 0);
        send_sample(0, 1);
        send_sample(0, 1022);
        send_sample(0, 1023);
        write_reg(acthq_pkg::CFG_PRESS, 1023);
        write_reg(acthq_pkg::CFG_RELEASE, 0);
        send_sample(0, 0);
        send_sample(3, 1023);
        send_sample(7, 1023);
    endtask

    // Mask upper data bits and the spare index must be ignored
    task automatic test_reg_decode();
        write_reg(acthq_pkg::CFG_MASK, 'h3FF);
        write_reg(CFG_SPARE, 'h155);
        send_sample(1, 1023);
        write_reg(acthq_pkg::CFG_MASK, 'h300);
        send_sample(1, 0);
        write_reg(acthq_pkg::CFG_PRESS, int'(acthq_pkg::PRESS_RST));
        write_reg(acthq_pkg::CFG_RELEASE, int'(acthq_pkg::RELEASE_RST));
    endtask

    // Random phases, each with its own register setting
    task automatic test_random_phases();
        int ch;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: write_reg(acthq_pkg::CFG_MASK, 0);
                1: write_reg(acthq_pkg::CFG_MASK, 'hFF);
                default: write_reg(acthq_pkg::CFG_MASK, $urandom_range(0, 1023));
            endcase
            write_reg(acthq_pkg::CFG_PRESS, pick_threshold());
            write_reg(acthq_pkg::CFG_RELEASE, pick_threshold());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // runs on one channel exercise the same-channel forwarding
                ch = $urandom_range(0, 1) ? prev_ch : $urandom_range(0, NCH - 1);
                send_sample(ch, pick_sample(ch));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_knob_map();
        test_button_hysteresis();
        test_threshold_extremes();
        test_reg_decode();
        test_random_phases();
        drain();
        repeat (8) @(negedge i_clk);
        err_cnt += cv_expected.size();
        if (err_cnt == 0) begin
            $display("adc_to_cc_hysteresis_qualifier_top verification clean");
        end else begin
            $display("adc_to_cc_hysteresis_qualifier_top verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/acthq_pkg.sv
design/acthq_mem.sv
design/acthq_eval.sv
design/adc_to_cc_hysteresis_qualifier_top.sv
tb/tb_adc_to_cc_hysteresis_qualifier_top.sv
